// ===== rtl/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman tree bit decoder package
// Shared types, codes and default sizes for the decoder's controller,
// datapath and checker.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DECODE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BAD_LEN = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    RD_NODE   = 2'd0,
    RD_CURSOR = 2'd1,
    RD_LINK   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  symbol_in;
    logic        coded_bit;
  } in_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [7:0] symbol_out;
    stat_t      status;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    bad_len;
    logic    ins_init;
    logic    ins_step;
    logic    ins_leaf;
    logic    dec_link;
    logic    dec_leaf;
    logic    out_load;
    rd_sel_t rd_sel;
  } ctl_cmd_t;

  typedef struct packed {
    func_t func;
    logic  len_bad;
    logic  link_zero;
    logic  store_full;
    logic  last_bit;
    logic  out_free;
  } ctl_stat_t;

endpackage

// ===== rtl/hufd_datapath.sv =====
// ----------------------------------------------------------------------------
// Huffman tree bit decoder datapath
// Node store memories, root links, allocation counter, decode cursor, tree
// walk logic and the output register.
// ----------------------------------------------------------------------------
module hufd_datapath #(
  parameter int NODE_COUNT   = hufd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = hufd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hufd_pkg::in_t       in_data,
  input  hufd_pkg::ctl_cmd_t  cmd,
  output hufd_pkg::ctl_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output hufd_pkg::out_t      out_data
);
  import hufd_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int FW = $clog2(NODE_COUNT + 1);
  localparam logic [FW-1:0] FULL_COUNT = FW'(NODE_COUNT);
  localparam logic [6:0]    LEN_LIMIT  = 7'(MAX_CODE_LEN);

  logic [NW-1:0] left_mem  [NODE_COUNT];
  logic [NW-1:0] right_mem [NODE_COUNT];
  logic [7:0]    sym_mem   [NODE_COUNT];
  logic          flag_mem  [NODE_COUNT];

  in_t           item;
  out_t          res;
  logic [NW-1:0] node;
  logic [NW-1:0] nxt;
  logic [NW-1:0] cursor;
  logic [NW-1:0] root_left;
  logic [NW-1:0] root_right;
  logic [5:0]    pos;
  logic [FW-1:0] free_count;
  logic          fresh;

  logic [NW-1:0] rd_left;
  logic [NW-1:0] rd_right;
  logic [7:0]    rd_sym;
  logic          rd_flag;
  logic [NW-1:0] rd_addr;

  logic [5:0]    bit_idx;
  logic          ins_bit;
  logic          dec_mode;
  logic [NW-1:0] walk_node;
  logic          walk_bit;
  logic          walk_fresh;
  logic [NW-1:0] link;
  logic          link_zero;
  logic          store_full;
  logic [NW-1:0] new_node;
  logic          grow;
  logic          node_nz;

  logic          left_we;
  logic          right_we;
  logic          leaf_we;
  logic [NW-1:0] left_wd;
  logic [NW-1:0] right_wd;
  logic [7:0]    sym_wd;

  assign bit_idx    = pos - 6'd1;
  assign ins_bit    = bit_idx[5] ? 1'b0 : item.code_bits[bit_idx[4:0]];
  assign dec_mode   = (item.func == FUNC_DECODE);
  assign walk_node  = dec_mode ? cursor : node;
  assign walk_bit   = dec_mode ? item.coded_bit : ins_bit;
  assign walk_fresh = !dec_mode && fresh;

  always_comb begin
    if (walk_node == '0) begin
      link = walk_bit ? root_right : root_left;
    end else if (walk_fresh) begin
      link = '0;
    end else begin
      link = walk_bit ? rd_right : rd_left;
    end
  end

  assign link_zero  = (link == '0);
  assign store_full = (free_count == FULL_COUNT);
  assign new_node   = free_count[NW-1:0];
  assign grow       = cmd.ins_step && link_zero && !store_full;
  assign node_nz    = (node != '0);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NODE:   rd_addr = node;
      RD_CURSOR: rd_addr = cursor;
      RD_LINK:   rd_addr = link;
      default:   rd_addr = node;
    endcase
  end

  // A new node gets its links written when the walk leaves it or ends on it.
  always_comb begin
    left_we  = (cmd.ins_step && link_zero && node_nz &&
                (fresh || (!store_full && !ins_bit))) || (cmd.ins_leaf && fresh);
    right_we = (cmd.ins_step && link_zero && node_nz &&
                (fresh || (!store_full && ins_bit))) || (cmd.ins_leaf && fresh);
    leaf_we  = (cmd.ins_step && link_zero && node_nz && fresh) || cmd.ins_leaf;
    left_wd  = (cmd.ins_step && !store_full && !ins_bit) ? new_node : '0;
    right_wd = (cmd.ins_step && !store_full && ins_bit) ? new_node : '0;
    sym_wd   = cmd.ins_leaf ? item.symbol_in : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[node] <= left_wd;
    end
    if (right_we) begin
      right_mem[node] <= right_wd;
    end
    if (leaf_we) begin
      flag_mem[node] <= cmd.ins_leaf;
      sym_mem[node]  <= sym_wd;
    end
    rd_left  <= left_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
    rd_flag  <= flag_mem[rd_addr];
    rd_sym   <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_left  <= '0;
      root_right <= '0;
      free_count <= FW'(1);
      cursor     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        root_left  <= '0;
        root_right <= '0;
        free_count <= FW'(1);
        cursor     <= '0;
      end else begin
        if (grow) begin
          free_count <= free_count + FW'(1);
          if (!node_nz && !ins_bit) begin
            root_left <= new_node;
          end
          if (!node_nz && ins_bit) begin
            root_right <= new_node;
          end
        end
        if (cmd.dec_link && link_zero) begin
          cursor <= '0;
        end else if (cmd.dec_leaf) begin
          cursor <= rd_flag ? '0 : nxt;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      res  <= '{symbol_valid: 1'b0, symbol_out: 8'd0, status: STAT_OK};
    end
    if (cmd.bad_len) begin
      res.status <= STAT_BAD_LEN;
    end
    if (cmd.ins_init) begin
      node  <= '0;
      pos   <= item.code_length;
      fresh <= 1'b0;
    end
    if (cmd.ins_step) begin
      if (link_zero && store_full) begin
        res.status <= STAT_FULL;
      end else begin
        node <= link_zero ? new_node : link;
        pos  <= pos - 6'd1;
        if (link_zero) begin
          fresh <= 1'b1;
        end
      end
    end
    if (cmd.dec_link) begin
      nxt <= link;
      if (link_zero) begin
        res.status <= STAT_MISSING;
      end
    end
    if (cmd.dec_leaf && rd_flag) begin
      res.symbol_valid <= 1'b1;
      res.symbol_out   <= rd_sym;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  assign stat.func       = item.func;
  assign stat.len_bad    = (item.code_length == 6'd0) ||
                           ({1'b0, item.code_length} > LEN_LIMIT);
  assign stat.link_zero  = link_zero;
  assign stat.store_full = store_full;
  assign stat.last_bit   = (pos == 6'd1);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/hufd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Huffman tree bit decoder controller
// State machine that sequences clear, insert walks and decode steps and
// hands each result to the output register.
// ----------------------------------------------------------------------------
module hufd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hufd_pkg::ctl_stat_t stat,
  output hufd_pkg::ctl_cmd_t  cmd
);
  import hufd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_I_LOOK,
    S_I_STEP,
    S_I_LEAF,
    S_D_LINK,
    S_D_LEAF,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NODE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.rd_sel = RD_CURSOR;
        unique case (stat.func)
          FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_FINISH;
          end
          FUNC_INSERT: begin
            if (stat.len_bad) begin
              cmd.bad_len = 1'b1;
              state_next  = S_FINISH;
            end else begin
              cmd.ins_init = 1'b1;
              state_next   = S_I_LOOK;
            end
          end
          FUNC_DECODE: begin
            state_next = S_D_LINK;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_I_LOOK: begin
        state_next = S_I_STEP;
      end
      S_I_STEP: begin
        cmd.ins_step = 1'b1;
        if (stat.link_zero && stat.store_full) begin
          state_next = S_FINISH;
        end else if (stat.last_bit) begin
          state_next = S_I_LEAF;
        end else begin
          state_next = S_I_LOOK;
        end
      end
      S_I_LEAF: begin
        cmd.ins_leaf = 1'b1;
        state_next   = S_FINISH;
      end
      S_D_LINK: begin
        cmd.dec_link = 1'b1;
        cmd.rd_sel   = RD_LINK;
        state_next   = stat.link_zero ? S_FINISH : S_D_LEAF;
      end
      S_D_LEAF: begin
        cmd.dec_leaf = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/huffman_tree_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Bit-serial decoder over a binary code tree kept in a node store.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one command: clear the tree, insert one
// code word with its symbol, or decode one coded bit. Every command yields
// exactly one result transfer carrying the symbol flag, the symbol and a
// status code. Commands are handled one at a time, and the node store has a
// single synchronous read port, so a decode bit takes one read for the child
// links and one for the leaf flag and symbol, or only the first read when the
// chosen branch is missing. An insert takes one read and one update per code
// bit, less when the store fills; an insert with a bad code length and a
// clear need no tree walk. A finished result waits in the output register
// while the next command is accepted; the following result is held back,
// and the input stays closed, until that register has been read.
module huffman_tree_bit_decoder #(
  parameter int NODE_COUNT   = hufd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = hufd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hufd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hufd_pkg::out_t out_data
);
  import hufd_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  hufd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hufd_datapath #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/hufd_checker.sv =====
// ----------------------------------------------------------------------------
// Huffman tree bit decoder checker
// Port-level checks on the decoder's handshakes and result fields.
// ----------------------------------------------------------------------------
module hufd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input hufd_pkg::out_t out_data
);
  import hufd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output is valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second command was taken before the first finished.");

  a_symbol_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.symbol_valid |-> out_data.status == STAT_OK)
    else $error("Decoded symbol reported with an error status.");

  a_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.symbol_valid |-> out_data.symbol_out == 8'd0)
    else $error("Symbol field is not zero without a decoded symbol.");

endmodule

bind huffman_tree_bit_decoder hufd_checker u_hufd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/huffman_tree_bit_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree bit decoder testbench
// Sends clear, insert and decode commands through the input channel and checks
// every result against a cycle-free model of the code tree, with random idle
// bursts on both channels.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_test;
  import hufd_pkg::*;

  localparam int NODES      = NODE_COUNT_DEF;
  localparam int CODE_MAX   = MAX_CODE_LEN_DEF;
  localparam int CMD_TARGET = 450;
  localparam int CALM_TAIL  = 60;
  localparam int LIMIT      = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  huffman_tree_bit_decoder DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Model of the code tree.
  logic [8:0] node_left [NODES];
  logic [8:0] node_right [NODES];
  logic [7:0] node_symbol [NODES];
  logic       node_is_leaf [NODES];
  logic [8:0] root_link [2];
  logic [9:0] nodes_used = 10'd1;
  logic [8:0] walk_node = 9'd0;

  in_t  pending_cmds[$];
  out_t predicted_results[$];
  int   send_gap = 0;
  int   hold_cycles = 0;
  int   cycles = 0;
  int   failures = 0;
  int   n_clear = 0, n_insert = 0, n_decode = 0;
  int   n_symbol = 0, n_missing = 0, n_full = 0, n_bad_len = 0;

  logic [31:0] book_bits [16];
  int          book_len [16];
  int          book_size;

  initial begin
    root_link[0] = '0;
    root_link[1] = '0;
  end

  function automatic logic [8:0] child_of(logic [8:0] node, logic br);
    if (node == 9'd0) begin
      return root_link[br];
    end
    return br ? node_right[node] : node_left[node];
  endfunction

  function automatic stat_t tree_insert(logic [31:0] bits, logic [5:0] len, logic [7:0] sym);
    logic [8:0] node;
    logic [8:0] next;
    logic       br;
    if (len == 6'd0 || int'(len) > CODE_MAX) begin
      return STAT_BAD_LEN;
    end
    node = 9'd0;
    for (int i = 0; i < int'(len); i++) begin
      br = bits[int'(len) - 1 - i];
      next = child_of(node, br);
      if (next == 9'd0) begin
        if (int'(nodes_used) >= NODES) begin
          return STAT_FULL;
        end
        next = nodes_used[8:0];
        nodes_used = nodes_used + 10'd1;
        node_left[next] = '0;
        node_right[next] = '0;
        node_is_leaf[next] = 1'b0;
        node_symbol[next] = '0;
        if (node == 9'd0) begin
          root_link[br] = next;
        end else if (br) begin
          node_right[node] = next;
        end else begin
          node_left[node] = next;
        end
      end
      node = next;
    end
    node_is_leaf[node] = 1'b1;
    node_symbol[node] = sym;
    return STAT_OK;
  endfunction

  function automatic out_t tree_step(in_t cmd);
    out_t       res;
    logic [8:0] next;
    res = '0;
    res.status = STAT_OK;
    case (cmd.func)
      FUNC_CLEAR: begin
        root_link[0] = '0;
        root_link[1] = '0;
        nodes_used = 10'd1;
        walk_node = '0;
      end
      FUNC_INSERT: begin
        res.status = tree_insert(cmd.code_bits, cmd.code_length, cmd.symbol_in);
      end
      FUNC_DECODE: begin
        next = child_of(walk_node, cmd.coded_bit);
        if (next == 9'd0) begin
          res.status = STAT_MISSING;
          walk_node = '0;
        end else if (node_is_leaf[next]) begin
          res.symbol_valid = 1'b1;
          res.symbol_out = node_symbol[next];
          walk_node = '0;
        end else begin
          walk_node = next;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic push_cmd(func_t f, logic [31:0] bits, logic [5:0] len, logic [7:0] sym,
                          logic br);
    in_t cmd;
    cmd.func = f;
    cmd.code_bits = bits;
    cmd.code_length = len;
    cmd.symbol_in = sym;
    cmd.coded_bit = br;
    pending_cmds.push_back(cmd);
  endtask

  task automatic push_plain(func_t f);
    push_cmd(f, $urandom, 6'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic push_insert(logic [31:0] bits, int len, logic [7:0] sym);
    push_cmd(FUNC_INSERT, bits, 6'(len), sym, 1'($urandom));
  endtask

  task automatic push_bit(logic br);
    push_cmd(FUNC_DECODE, $urandom, 6'($urandom), 8'($urandom), br);
  endtask

  // Fills the node store: twenty length-32 codes with distinct leading bits
  // need more nodes than the store holds.
  task automatic push_fill();
    logic [4:0] head;
    push_plain(FUNC_CLEAR);
    for (int i = 0; i < 20; i++) begin
      head = 5'(i);
      push_insert({head, 27'($urandom)}, CODE_MAX, 8'($urandom));
    end
    for (int i = 0; i < 5; i++) begin
      push_bit(1'($urandom));
    end
  endtask

  task automatic push_episode();
    int len;
    int pick;
    int cut;
    if ($urandom_range(0, 2) == 0) begin
      push_plain(FUNC_CLEAR);
    end
    book_size = $urandom_range(2, 8);
    for (int k = 0; k < book_size; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, CODE_MAX) : $urandom_range(1, 6);
      book_len[k] = len;
      book_bits[k] = $urandom;
      push_insert(book_bits[k], len, 8'($urandom));
      if ($urandom_range(0, 11) == 0) begin
        push_insert($urandom, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63),
                    8'($urandom));
      end
    end
    for (int m = $urandom_range(3, 10); m > 0; m--) begin
      pick = $urandom_range(0, book_size - 1);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, book_len[pick]) : book_len[pick];
      for (int b = 0; b < cut; b++) begin
        push_bit(book_bits[pick][book_len[pick] - 1 - b]);
      end
      if ($urandom_range(0, 7) == 0) begin
        push_bit(1'($urandom));
      end
      if ($urandom_range(0, 15) == 0) begin
        push_plain(func_t'(2'd3));
      end
    end
  endtask

  initial begin
    // Directed part: empty tree, unused function, bad lengths, repeated codes,
    // prefix conflicts and an insert in the middle of a code.
    push_plain(FUNC_CLEAR);
    push_plain(func_t'(2'd3));
    push_bit(1'b0);
    push_insert(32'hFFFF_FFFF, 0, 8'h11);
    push_insert(32'h0000_0000, 33, 8'h22);
    push_insert(32'hFFFF_FFFF, 63, 8'h33);
    push_insert(32'h0000_0000, 1, 8'h00);
    push_insert(32'h0000_0002, 2, 8'hFF);
    push_insert(32'h0000_0006, 3, 8'h5A);
    push_bit(1'b1);
    push_insert(32'h0000_0007, 3, 8'hA5);
    push_bit(1'b1);
    push_bit(1'b1);
    push_bit(1'b0);
    push_insert(32'hFFFF_FFFE, 1, 8'h3C);
    push_bit(1'b0);
    push_bit(1'b1);
    push_bit(1'b0);
    push_insert(32'h0000_0001, 1, 8'h77);
    push_bit(1'b1);
    push_insert(32'hFFFF_FFFF, 4, 8'h81);
    push_bit(1'b1);
    push_insert(32'hFFFF_FFFF, CODE_MAX, 8'hC3);
    push_plain(FUNC_CLEAR);
    push_bit(1'b1);
    push_fill();
    while (pending_cmds.size() < CMD_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        push_fill();
      end else begin
        push_episode();
      end
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(tree_step(in_data));
        case (in_data.func)
          FUNC_CLEAR: n_clear++;
          FUNC_INSERT: n_insert++;
          FUNC_DECODE: n_decode++;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no command outstanding: %p", out_data);
          failures++;
        end else begin
          automatic out_t want = predicted_results.pop_front();
          if (out_data.symbol_valid !== want.symbol_valid) begin
            $error("symbol_valid: expected %0d, actual %0d", want.symbol_valid,
                   out_data.symbol_valid);
            failures++;
          end
          if (out_data.symbol_out !== want.symbol_out) begin
            $error("symbol_out: expected 0x%02h, actual 0x%02h", want.symbol_out,
                   out_data.symbol_out);
            failures++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            failures++;
          end
          if (want.symbol_valid) n_symbol++;
          case (want.status)
            STAT_MISSING: n_missing++;
            STAT_FULL: n_full++;
            STAT_BAD_LEN: n_bad_len++;
            default: begin
            end
          endcase
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        hold_cycles = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    while (pending_cmds.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    $display("Sent %0d clears, %0d inserts and %0d decode bits in %0d cycles.",
             n_clear, n_insert, n_decode, cycles);
    $display("Saw %0d symbols, %0d missing branches, %0d full stores, %0d bad lengths.",
             n_symbol, n_missing, n_full, n_bad_len);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
